>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

>>> rtl/core/crt2_pkg.sv
// Package for the two-moduli CRT combiner: widths, reset values, types.
// No dependencies.
package crt2_pkg;
  localparam int ModW  = 31;
  localparam int ProdW = 62;
  localparam int DvdW  = 33;
  localparam logic [ModW-1:0] Mod1Reset = 31'd1000000007;
  localparam logic [ModW-1:0] Mod2Reset = 31'd1000000009;
  localparam logic RegMod1 = 1'b0;
  localparam logic RegMod2 = 1'b1;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [ModW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quot;
    logic [ModW-1:0] rem;
  } div_rsp_t;
endpackage

>>> rtl/core/crt2_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on crt2_pkg.
module crt2_div import crt2_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [DvdW-1:0] dvd;
  logic [ModW-1:0] rem;
  logic [ModW-1:0] dsr;
  logic [5:0]      cnt;
  logic            busy;
  logic            done;
  logic [ModW:0]   rsh;
  logic            ge;

  assign rsh = {rem, dvd[DvdW-1]};
  assign ge  = (rsh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? ModW'(rsh - {1'b0, dsr}) : rsh[ModW-1:0];
        dvd <= {dvd[DvdW-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DvdW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;
endmodule

>>> rtl/core/crt_two_moduli_combine_top.sv
// Two-moduli CRT combiner top: sequencer, Euclid, doubling modular multiply.
// Depends on crt2_pkg, crt2_div, assert_macros.svh.
//
//  channel | signals                                    | dir
//  in      | in_valid/in_ready, residue_first/second     | request in
//  out     | out_valid/out_ready, combined_value, coprime| request out
//  cfg     | cfg_we, cfg_index, cfg_data                 | write only
//
// Every division runs on the shared 33-step divider. A request with nonzero
// moduli does four reductions, up to 46 Euclid steps plus a final mod per
// inverse, then four doubling multiplies.
// Synchronous reset returns to idle and loads the default moduli.
// in_ready is high only when idle; a result holds until out_ready.
`include "assert_macros.svh"
module crt_two_moduli_combine_top import crt2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ModW-1:0]  residue_first,
  input  logic [ModW-1:0]  residue_second,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ProdW-1:0] combined_value,
  output logic             moduli_coprime,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [ModW-1:0]  cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_RED1, S_RED2, S_A1, S_A2, S_EU, S_EUQ, S_EUS,
    S_EUFIN, S_EUMOD, S_PROD, S_PRODD, S_MM, S_OUT
  } state_t;

  state_t state, ret;
  logic [ModW-1:0]  m1, m2, r1, r2, e_r0, e_r1, q, inv1, inv2;
  logic signed [DvdW-1:0] s0, s1;
  logic             pass;
  logic [1:0]       phase;
  logic [ProdW-1:0] prod, ma, acc, aval;
  logic [ModW-1:0]  mb;
  logic signed [65:0] mprod;
  logic signed [DvdW-1:0] mul_a, mul_b;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic [DvdW-1:0]  d_dvd;
  logic [ModW-1:0]  d_dsr;
  logic             prev_wait;
  logic [ModW-1:0]  inv;
  logic [DvdW-1:0]  s0_abs;

  function automatic logic [ProdW-1:0] add_mod(input logic [ProdW-1:0] x,
      input logic [ProdW-1:0] y, input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[ProdW-1:0];
  endfunction

  crt2_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // divider starts in the first cycle of each wait
  assign dreq = '{start: (state == S_WAIT) && !prev_wait, dividend: d_dvd, divisor: d_dsr};

  assign mul_a  = (state == S_PROD) ? $signed({2'b0, m1}) : $signed({2'b0, drsp.quot[ModW-1:0]});
  assign mul_b  = (state == S_PROD) ? $signed({2'b0, m2}) : s1;
  assign s0_abs = s0[DvdW-1] ? DvdW'(-s0) : DvdW'(s0);
  assign inv    = (s0[DvdW-1] && drsp.rem != '0) ? ModW'(q - drsp.rem) : drsp.rem;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    mprod <= mul_a * mul_b;
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      out_valid  <= 1'b0;
      prev_wait  <= 1'b0;
      m1         <= Mod1Reset;
      m2         <= Mod2Reset;
    end else begin
      prev_wait <= (state == S_WAIT);
      if (cfg_we) begin
        if (cfg_index == RegMod1) m1 <= cfg_data;
        else                      m2 <= cfg_data;
      end
      case (state)
        S_IDLE: if (in_valid) begin
          r1 <= residue_first;
          r2 <= residue_second;
          if (m1 == '0 || m2 == '0) begin
            combined_value <= '0;
            moduli_coprime <= 1'b0;
            out_valid      <= 1'b1;
            state          <= S_OUT;
          end else begin
            d_dvd <= {2'b0, residue_first};
            d_dsr <= m1;
            ret  <= S_RED1;
            state <= S_WAIT;
          end
        end
        S_WAIT: if (drsp.done) state <= ret;
        S_RED1: begin
          r1    <= drsp.rem;
          d_dvd <= {2'b0, r2};
          d_dsr <= m2;
          ret   <= S_RED2;
          state <= S_WAIT;
        end
        S_RED2: begin
          r2    <= drsp.rem;
          pass  <= 1'b0;
          d_dvd <= {2'b0, m2};
          d_dsr <= m1;
          ret   <= S_A1;
          state <= S_WAIT;
        end
        S_A1, S_A2: begin
          e_r0  <= drsp.rem;
          e_r1  <= (state == S_A1) ? m1 : m2;
          q     <= (state == S_A1) ? m1 : m2;
          s0    <= DvdW'(1);
          s1    <= '0;
          state <= S_EU;
        end
        S_EU: begin
          if (e_r1 == '0) begin
            state <= S_EUFIN;
          end else begin
            d_dvd <= {2'b0, e_r0};
            d_dsr <= e_r1;
            ret   <= S_EUQ;
            state <= S_WAIT;
          end
        end
        S_EUQ: begin
          e_r0  <= e_r1;
          e_r1  <= drsp.rem;
          state <= S_EUS;
        end
        S_EUS: begin
          s0    <= s1;
          s1    <= s0 - mprod[DvdW-1:0];
          state <= S_EU;
        end
        S_EUFIN: begin
          if (!pass) moduli_coprime <= (e_r0 == ModW'(1));
          d_dvd <= s0_abs;
          d_dsr <= q;
          ret   <= S_EUMOD;
          state <= S_WAIT;
        end
        S_EUMOD: begin
          if (!pass) begin
            inv2  <= inv;
            pass  <= 1'b1;
            d_dvd <= {2'b0, m1};
            d_dsr <= m2;
            ret   <= S_A2;
            state <= S_WAIT;
          end else begin
            inv1  <= inv;
            state <= S_PROD;
          end
        end
        S_PROD: state <= S_PRODD;
        S_PRODD: begin
          prod  <= mprod[ProdW-1:0];
          ma    <= {31'b0, r1};
          mb    <= inv2;
          acc   <= '0;
          phase <= 2'd0;
          state <= S_MM;
        end
        S_MM: begin
          if (mb == '0) begin
            acc   <= '0;
            phase <= phase + 2'd1;
            case (phase)
              2'd0: begin ma <= acc; mb <= m2; end
              2'd1: begin aval <= acc; ma <= {31'b0, r2}; mb <= inv1; end
              2'd2: begin ma <= acc; mb <= m1; end
              default: begin
                combined_value <= add_mod(aval, acc, prod);
                out_valid      <= 1'b1;
                state          <= S_OUT;
              end
            endcase
          end else begin
            if (mb[0]) acc <= add_mod(acc, ma, prod);
            ma <= add_mod(ma, ma, prod);
            mb <= mb >> 1;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_rdy_excl, clk, rst, in_ready, !out_valid, "ready while result pending")
  `ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `ASSERT_IMP(a_range, clk, rst, out_valid, combined_value < prod || combined_value == '0, "unreduced")
endmodule
